>>> hdl/lprs_pkg.sv
package lprs_pkg;

    // Field and register widths
    localparam int SAMPLE_W  = 16;
    localparam int PHASE_W   = 41;
    localparam int ACC_W     = 42;
    localparam int FRAC_W    = 32;
    localparam int INDEX_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Results produced by one frame at most
    localparam int MAX_RESULTS = 64;
    localparam int RUN_W       = 7;

    // Queue depths
    localparam int IN_DEPTH_DEF  = 2;
    localparam int OUT_DEPTH_DEF = 4;

    // One whole input frame in 10.32 phase units
    localparam logic [ACC_W-1:0] ONE_FRAME = 42'h100_0000_0000 >> 8;

    // Register reset values
    localparam logic [PHASE_W-1:0] STEP_RESET    = 41'h1_0000_0000;
    localparam logic               STEREO_RESET  = 1'b1;
    localparam logic [INDEX_W-1:0] MAX_OUT_RESET = 16'hFFFF;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP = 2'd0,
        CFG_STEREO     = 2'd1,
        CFG_MAX_OUT    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_step;
        logic               stereo;
        logic [INDEX_W-1:0] max_out;
    } t_cfg;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       last;
    } t_frame;

    // One output to compute: endpoints, fraction, position, run end
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] prev_l;
        logic signed [SAMPLE_W-1:0] prev_r;
        logic signed [SAMPLE_W-1:0] cur_l;
        logic signed [SAMPLE_W-1:0] cur_r;
        logic [FRAC_W-1:0]          frac;
        logic [INDEX_W-1:0]         index;
        logic                       last;
    } t_job;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic [INDEX_W-1:0]         index;
        logic                       last;
    } t_result;

endpackage

>>> hdl/lprs_front.sv
module lprs_front #(
    parameter int IN_DEPTH = lprs_pkg::IN_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  lprs_pkg::t_frame i_frame,
    output logic            o_frame_valid,
    output lprs_pkg::t_frame o_frame,
    input  logic            i_frame_pop
);
    import lprs_pkg::*;

    localparam int PTR_W = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
    localparam int CNT_W = $clog2(IN_DEPTH + 1);

    t_frame             r_mem [IN_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               wr_en, rd_en;

    // Frame queue handshake
    assign full          = (r_count == CNT_W'(IN_DEPTH));
    assign wr_en         = push && !full;
    assign o_frame_valid = (r_count != '0);
    assign rd_en         = i_frame_pop && o_frame_valid;
    assign o_frame       = r_mem[r_rd_ptr];

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(IN_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(IN_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + CNT_W'(1);
        end else if (rd_en && !wr_en) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Frame storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

endmodule

>>> hdl/lprs_seq.sv
module lprs_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lprs_pkg::t_cfg   i_cfg,
    input  logic             i_frame_valid,
    input  lprs_pkg::t_frame i_frame,
    output logic             o_frame_pop,
    input  logic             i_credit,
    output logic             o_job_valid,
    output lprs_pkg::t_job   o_job
);
    import lprs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INTERP,
        ST_TAIL
    } t_state;

    t_state                     r_state, n_state;
    logic signed [SAMPLE_W-1:0] r_prev_l, n_prev_l;
    logic signed [SAMPLE_W-1:0] r_prev_r, n_prev_r;
    logic                       r_have_prev, n_have_prev;
    logic [ACC_W-1:0]           r_phase, n_phase;
    logic [INDEX_W-1:0]         r_count, n_count;
    logic [RUN_W-1:0]           r_n, n_n;
    logic signed [SAMPLE_W-1:0] r_cur_l, n_cur_l;
    logic signed [SAMPLE_W-1:0] r_cur_r, n_cur_r;
    logic                       r_last, n_last;

    logic [ACC_W-1:0] phase_nxt;
    logic [ACC_W-1:0] phase_wrap;
    logic [ACC_W-1:0] nxt_wrap;
    logic             room_now, room_next;
    logic             emit_ok, next_interp, next_tail;
    logic             interp_last, tail_last;
    logic             busy;

    // Phase advance and the frame-boundary wrap of now and of next
    assign phase_nxt  = r_phase + {1'b0, i_cfg.phase_step};
    assign phase_wrap = (r_phase >= ONE_FRAME)
                        ? {1'b0, PHASE_W'(r_phase - ONE_FRAME)} : '0;
    assign nxt_wrap   = (phase_nxt >= ONE_FRAME) ? (phase_nxt - ONE_FRAME) : '0;

    // Limits: results per frame and outputs per buffer
    assign room_now  = (r_n < RUN_W'(MAX_RESULTS)) && (r_count < i_cfg.max_out);
    assign room_next = (r_n < RUN_W'(MAX_RESULTS - 1))
                       && (({1'b0, r_count} + 17'd1) < {1'b0, i_cfg.max_out});

    assign emit_ok     = (r_phase < ONE_FRAME) && room_now;
    assign next_interp = (phase_nxt < ONE_FRAME) && room_next;
    assign next_tail   = (nxt_wrap < ONE_FRAME) && room_next;

    // Run end: no further output from this frame, tail included
    assign interp_last = !next_interp && !(r_last && next_tail);
    assign tail_last   = !next_interp;

    // Issue one output per cycle while the result side has room
    assign busy        = (r_state == ST_INTERP) || (r_state == ST_TAIL);
    assign o_job_valid = busy && emit_ok && i_credit;
    assign o_frame_pop = (r_state == ST_IDLE) && i_frame_valid;

    always_comb begin
        o_job.prev_l = (r_state == ST_TAIL) ? r_cur_l : r_prev_l;
        o_job.prev_r = (r_state == ST_TAIL) ? r_cur_r : r_prev_r;
        o_job.cur_l  = r_cur_l;
        o_job.cur_r  = r_cur_r;
        o_job.frac   = (r_state == ST_TAIL) ? '0 : r_phase[FRAC_W-1:0];
        o_job.index  = r_count;
        o_job.last   = (r_state == ST_TAIL) ? tail_last : interp_last;
    end

    // Sequencer next state
    always_comb begin
        n_state     = r_state;
        n_prev_l    = r_prev_l;
        n_prev_r    = r_prev_r;
        n_have_prev = r_have_prev;
        n_phase     = r_phase;
        n_count     = r_count;
        n_n         = r_n;
        n_cur_l     = r_cur_l;
        n_cur_r     = r_cur_r;
        n_last      = r_last;
        case (r_state)
            ST_IDLE: begin
                if (i_frame_valid) begin
                    n_cur_l = i_frame.left;
                    n_cur_r = i_frame.right;
                    n_last  = i_frame.last;
                    n_n     = '0;
                    if (r_have_prev) begin
                        n_state = ST_INTERP;
                    end else begin
                        // first frame of a buffer only becomes the previous one
                        n_prev_l    = i_frame.left;
                        n_prev_r    = i_frame.right;
                        n_have_prev = 1'b1;
                        if (i_frame.last) begin
                            n_state = ST_TAIL;
                        end
                    end
                end
            end
            ST_INTERP: begin
                if (emit_ok) begin
                    if (i_credit) begin
                        n_phase = phase_nxt;
                        n_n     = r_n + RUN_W'(1);
                        n_count = r_count + INDEX_W'(1);
                    end
                end else begin
                    n_phase     = phase_wrap;
                    n_prev_l    = r_cur_l;
                    n_prev_r    = r_cur_r;
                    n_have_prev = 1'b1;
                    n_state     = r_last ? ST_TAIL : ST_IDLE;
                end
            end
            ST_TAIL: begin
                if (emit_ok) begin
                    if (i_credit) begin
                        n_phase = phase_nxt;
                        n_n     = r_n + RUN_W'(1);
                        n_count = r_count + INDEX_W'(1);
                    end
                end else begin
                    // buffer ends: back to the cleared state
                    n_prev_l    = '0;
                    n_prev_r    = '0;
                    n_have_prev = 1'b0;
                    n_phase     = '0;
                    n_count     = '0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_prev_l    <= '0;
            r_prev_r    <= '0;
            r_have_prev <= 1'b0;
            r_phase     <= '0;
            r_count     <= '0;
            r_n         <= '0;
            r_last      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prev_l    <= n_prev_l;
            r_prev_r    <= n_prev_r;
            r_have_prev <= n_have_prev;
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_n         <= n_n;
            r_last      <= n_last;
        end
        r_cur_l <= n_cur_l;
        r_cur_r <= n_cur_r;
    end

    // Issue never outruns the result queue's room
    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid |-> i_credit)
        else $error("output issued without result queue room");

    // Per-frame result count stays within its bound
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= RUN_W'(MAX_RESULTS))
        else $error("too many outputs for one frame");

    // Without a previous frame the phase and index are clear
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && !r_have_prev) |-> (r_phase == '0 && r_count == '0))
        else $error("state not cleared between buffers");

    // The flagged run end is really the last output of that frame
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_job_valid && o_job.last) |=> !o_job_valid)
        else $error("output issued after run end");

endmodule

>>> hdl/lprs_out.sv
module lprs_out #(
    parameter int OUT_DEPTH = lprs_pkg::OUT_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_stereo,
    input  logic              i_job_valid,
    input  lprs_pkg::t_job    i_job,
    output logic              o_credit,
    output logic              empty,
    input  logic              pop,
    output lprs_pkg::t_result o_result
);
    import lprs_pkg::*;

    localparam int PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);
    localparam int DIF_W = SAMPLE_W + 1;
    localparam int PRD_W = DIF_W + FRAC_W + 1;

    // Stage 1: differences
    logic                       r_s1_v;
    logic signed [SAMPLE_W-1:0] r_s1_prev_l, r_s1_prev_r;
    logic signed [DIF_W-1:0]    r_s1_diff_l, r_s1_diff_r;
    logic [FRAC_W-1:0]          r_s1_frac;
    logic [INDEX_W-1:0]         r_s1_index;
    logic                       r_s1_last;

    // Stage 2: scaled differences
    logic                       r_s2_v;
    logic signed [SAMPLE_W-1:0] r_s2_prev_l, r_s2_prev_r;
    logic [SAMPLE_W-1:0]        r_s2_step_l, r_s2_step_r;
    logic [INDEX_W-1:0]         r_s2_index;
    logic                       r_s2_last;

    logic signed [PRD_W-1:0]    prod_l, prod_r;
    t_result                    wr_word;

    t_result                    r_mem [OUT_DEPTH];
    logic [PTR_W-1:0]           r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]           r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]           r_count, n_count;
    logic [CNT_W:0]             pending;
    logic                       rd_en;

    // Queue room counts outputs still in the pipeline
    assign pending  = {1'b0, r_count} + (CNT_W + 1)'(r_s1_v) + (CNT_W + 1)'(r_s2_v);
    assign o_credit = (pending < (CNT_W + 1)'(OUT_DEPTH));

    // Signed difference times unsigned fraction; floor by arithmetic shift
    assign prod_l = r_s1_diff_l * $signed({1'b0, r_s1_frac});
    assign prod_r = r_s1_diff_r * $signed({1'b0, r_s1_frac});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= i_job_valid;
            r_s2_v <= r_s1_v;
        end
        r_s1_prev_l <= i_job.prev_l;
        r_s1_prev_r <= i_job.prev_r;
        r_s1_diff_l <= DIF_W'(i_job.cur_l) - DIF_W'(i_job.prev_l);
        r_s1_diff_r <= DIF_W'(i_job.cur_r) - DIF_W'(i_job.prev_r);
        r_s1_frac   <= i_job.frac;
        r_s1_index  <= i_job.index;
        r_s1_last   <= i_job.last;
        r_s2_prev_l <= r_s1_prev_l;
        r_s2_prev_r <= r_s1_prev_r;
        r_s2_step_l <= prod_l[FRAC_W +: SAMPLE_W];
        r_s2_step_r <= prod_r[FRAC_W +: SAMPLE_W];
        r_s2_index  <= r_s1_index;
        r_s2_last   <= r_s1_last;
    end

    // Final add; right word forced to zero in mono
    always_comb begin
        wr_word.left  = r_s2_prev_l + r_s2_step_l;
        wr_word.right = i_stereo ? (r_s2_prev_r + r_s2_step_r) : '0;
        wr_word.index = r_s2_index;
        wr_word.last  = r_s2_last;
    end

    // Result queue
    assign empty    = (r_count == '0);
    assign rd_en    = pop && !empty;
    assign o_result = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (r_s2_v) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (r_s2_v && !rd_en) begin
            n_count = r_count + CNT_W'(1);
        end else if (rd_en && !r_s2_v) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_v) begin
            r_mem[r_wr_ptr] <= wr_word;
        end
    end

endmodule

>>> hdl/linear_pcm_resampler_s16.sv
// Path: a frame's first output word passes the input queue, the sequencer's frame
// registers, the difference and scaled-difference stages and the result queue. The
// sequencer takes a new frame only when idle; a first frame that does not end the
// buffer only becomes the previous one. Words stream at one per cycle while popped.
// Reset (synchronous, active low) empties both queues, clears the phase and
// buffer state, and loads step 1.0, stereo mode and 65535 max outputs.
module linear_pcm_resampler_s16 #(
    parameter int IN_DEPTH  = lprs_pkg::IN_DEPTH_DEF,
    parameter int OUT_DEPTH = lprs_pkg::OUT_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [lprs_pkg::SAMPLE_W-1:0]  i_left_sample,
    input  logic signed [lprs_pkg::SAMPLE_W-1:0]  i_right_sample,
    input  logic                                  i_last_frame,
    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [lprs_pkg::SAMPLE_W-1:0]  o_left_out,
    output logic signed [lprs_pkg::SAMPLE_W-1:0]  o_right_out,
    output logic        [lprs_pkg::INDEX_W-1:0]   o_out_index,
    output logic                                  o_last_of_run,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic        [lprs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [lprs_pkg::PHASE_W-1:0]   i_cfg_data
);
    import lprs_pkg::*;

    t_cfg    r_cfg;
    t_frame  in_frame, q_frame;
    logic    q_valid, q_pop;
    logic    job_valid, credit;
    t_job    job;
    t_result result;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step <= STEP_RESET;
            r_cfg.stereo     <= STEREO_RESET;
            r_cfg.max_out    <= MAX_OUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PHASE_STEP: r_cfg.phase_step <= i_cfg_data;
                CFG_STEREO:     r_cfg.stereo     <= i_cfg_data[0];
                CFG_MAX_OUT:    r_cfg.max_out    <= i_cfg_data[INDEX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign in_frame.left  = i_left_sample;
    assign in_frame.right = i_right_sample;
    assign in_frame.last  = i_last_frame;

    lprs_front #(
        .IN_DEPTH(IN_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_frame       (in_frame),
        .o_frame_valid (q_valid),
        .o_frame       (q_frame),
        .i_frame_pop   (q_pop)
    );

    lprs_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_frame_valid (q_valid),
        .i_frame       (q_frame),
        .o_frame_pop   (q_pop),
        .i_credit      (credit),
        .o_job_valid   (job_valid),
        .o_job         (job)
    );

    lprs_out #(
        .OUT_DEPTH(OUT_DEPTH)
    ) u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stereo    (r_cfg.stereo),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_credit    (credit),
        .empty       (empty),
        .pop         (pop),
        .o_result    (result)
    );

    assign o_left_out    = result.left;
    assign o_right_out   = result.right;
    assign o_out_index   = result.index;
    assign o_last_of_run = result.last;

endmodule

>>> sim/linear_pcm_resampler_s16_tb.sv
module linear_pcm_resampler_s16_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lprs_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int IDLE_PCT     = 14;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 30;
    localparam int STALL_LIMIT  = 4000;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_FRAMES = 27;
    localparam int SHOW_LIMIT   = 40;

    localparam logic [PHASE_W-1:0] STEP_ONE     = 41'h1_0000_0000;
    localparam logic [PHASE_W-1:0] STEP_HALF    = 41'h0_8000_0000;
    localparam logic [PHASE_W-1:0] STEP_QUARTER = 41'h0_4000_0000;
    localparam logic [PHASE_W-1:0] STEP_MIN     = 41'd134217728;
    localparam logic [PHASE_W-1:0] STEP_MAX     = 41'h100_0000_0000;

    // Tracks the resampler's phase and buffer state and the output words
    // it owes.
    class resampler_scoreboard;
        localparam logic [63:0] FRAME_UNIT = 64'h1_0000_0000;
        localparam logic [63:0] PHASE_MASK = 64'h1FF_FFFF_FFFF;

        // register copies
        logic [PHASE_W-1:0]         step;
        logic                       stereo;
        logic [INDEX_W-1:0]         max_out;
        // buffer state
        logic signed [SAMPLE_W-1:0] prev_l;
        logic signed [SAMPLE_W-1:0] prev_r;
        logic                       have_prev;
        logic [63:0]                phase;
        logic [INDEX_W-1:0]         out_cnt;
        // newest word of a run, held back until the run's end is known
        t_result                    held;
        logic                       have_held;
        int                         run_len;
        t_result                    pending_words[$];
        int                         errors;
        int                         frames;
        int                         words;
        int                         shown;

        function new();
            step      = STEP_RESET;
            stereo    = STEREO_RESET;
            max_out   = MAX_OUT_RESET;
            have_held = 1'b0;
            errors    = 0;
            frames    = 0;
            words     = 0;
            shown     = 0;
            clear_buffer();
        endfunction

        function void clear_buffer();
            prev_l    = '0;
            prev_r    = '0;
            have_prev = 1'b0;
            phase     = '0;
            out_cnt   = '0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [PHASE_W-1:0] value);
            case (idx)
                CFG_PHASE_STEP: step = value;
                CFG_STEREO:     stereo = value[0];
                CFG_MAX_OUT:    max_out = value[INDEX_W-1:0];
                default: ;
            endcase
        endfunction

        // a + floor((b - a) * frac / 2^32)
        function logic signed [SAMPLE_W-1:0] interpolate(logic signed [SAMPLE_W-1:0] a,
                                                        logic signed [SAMPLE_W-1:0] b,
                                                        logic [FRAC_W-1:0] frac);
            longint diff;
            longint prod;
            diff = longint'(b) - longint'(a);
            prod = diff * $signed({32'd0, frac});
            return SAMPLE_W'(longint'(a) + (prod >>> 32));
        endfunction

        function void add_word(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
            t_result w;
            w.left  = l;
            w.right = stereo ? r : '0;
            w.index = out_cnt;
            w.last  = 1'b0;
            if (have_held) pending_words.push_back(held);
            held      = w;
            have_held = 1'b1;
            out_cnt   = out_cnt + 1'b1;
            run_len++;
        endfunction

        function bit room_left();
            return phase < FRAME_UNIT && run_len < MAX_RESULTS && out_cnt < max_out;
        endfunction

        // Work out the words one accepted frame gives.
        function void note_frame(logic signed [SAMPLE_W-1:0] l,
                                 logic signed [SAMPLE_W-1:0] r, logic last);
            run_len = 0;
            if (have_prev) begin
                while (room_left()) begin
                    add_word(interpolate(prev_l, l, phase[FRAC_W-1:0]),
                             interpolate(prev_r, r, phase[FRAC_W-1:0]));
                    phase = phase + step;
                end
                if (phase >= FRAME_UNIT) phase = (phase - FRAME_UNIT) & PHASE_MASK;
                else phase = '0;
            end
            prev_l    = l;
            prev_r    = r;
            have_prev = 1'b1;
            // buffer end: remaining words repeat this frame
            if (last) begin
                while (room_left()) begin
                    add_word(l, r);
                    phase = phase + step;
                end
                clear_buffer();
            end
            if (have_held) begin
                held.last = 1'b1;
                pending_words.push_back(held);
                have_held = 1'b0;
            end
            frames++;
        endfunction

        function void compare_field(string name, longint exp_v, longint got_v);
            if (exp_v != got_v) begin
                errors++;
                if (shown < SHOW_LIMIT)
                    $display("%0t: %s mismatch, expected %0d, got %0d",
                             $time, name, exp_v, got_v);
                shown++;
            end
        endfunction

        function void check_word(t_result got);
            t_result exp_w;
            if (pending_words.size() == 0) begin
                errors++;
                $display("%0t: output word with nothing pending, expected none, got index %0d",
                         $time, got.index);
                return;
            end
            exp_w = pending_words.pop_front();
            words++;
            compare_field("left_out", exp_w.left, got.left);
            compare_field("right_out", exp_w.right, got.right);
            compare_field("out_index", exp_w.index, got.index);
            compare_field("last_of_run", exp_w.last, got.last);
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       push;
    logic                       full;
    logic signed [SAMPLE_W-1:0] i_left_sample;
    logic signed [SAMPLE_W-1:0] i_right_sample;
    logic                       i_last_frame;
    logic                       empty;
    logic                       pop;
    logic signed [SAMPLE_W-1:0] o_left_out;
    logic signed [SAMPLE_W-1:0] o_right_out;
    logic [INDEX_W-1:0]         o_out_index;
    logic                       o_last_of_run;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [PHASE_W-1:0]         i_cfg_data;

    resampler_scoreboard sb;
    bit                  no_idle = 1'b0;
    bit                  hold_req = 1'b0;
    int                  hold_left = 0;
    int                  stall_cycles = 0;
    int                  cfg_writes = 0;
    bit                  moved;
    t_result             got_word;

    linear_pcm_resampler_s16 u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_last_frame   (i_last_frame),
        .empty          (empty),
        .pop            (pop),
        .o_left_out     (o_left_out),
        .o_right_out    (o_right_out),
        .o_out_index    (o_out_index),
        .o_last_of_run  (o_last_of_run),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Offer one frame; returns just after the falling edge following its
    // acceptance, with push still high.
    task automatic push_frame(input logic signed [SAMPLE_W-1:0] l,
                              input logic signed [SAMPLE_W-1:0] r, input logic last);
        if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        push           <= 1'b1;
        i_left_sample  <= l;
        i_right_sample <= r;
        i_last_frame   <= last;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    task automatic write_one(input t_cfg_idx idx, input logic [PHASE_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic write_regs(input logic [PHASE_W-1:0] step, input logic stereo,
                              input logic [INDEX_W-1:0] max_out);
        write_one(CFG_PHASE_STEP, step);
        write_one(CFG_STEREO, PHASE_W'(stereo));
        write_one(CFG_MAX_OUT, PHASE_W'(max_out));
        i_cfg_valid <= 1'b0;
    endtask

    // Stop offering, let every owed word out, then give frames that make
    // no word time to leave the pipeline.
    task automatic wait_drain();
        push <= 1'b0;
        while (sb.pending_words.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [PHASE_W-1:0] rand_step(longint unsigned lo, longint unsigned hi);
        longint unsigned r;
        r = {$urandom, $urandom};
        return PHASE_W'(lo + r % (hi - lo + 1));
    endfunction

    // Smooth audio around the last value, mixed with extremes and noise.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample(logic signed [SAMPLE_W-1:0] near);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 16'sh8000;
        if (sel == 1) return 16'sh7FFF;
        if (sel < 6) return near + SAMPLE_W'($urandom_range(0, 1023)) - 16'sd512;
        return SAMPLE_W'($urandom);
    endfunction

    // Reader: random pops, plus one long hold-off on request.
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                pop <= 1'b0;
            end else begin
                pop <= no_idle || $urandom_range(0, 99) >= IDLE_PCT;
            end
        end
    end

    // Monitor: every accepted frame, popped word and register write goes to the scoreboard; watchdog on stalls.
    always @(posedge i_clk) begin
        moved = 1'b0;
        if (push && !full) begin
            sb.note_frame(i_left_sample, i_right_sample, i_last_frame);
            moved = 1'b1;
        end
        if (pop && !empty) begin
            got_word.left  = o_left_out;
            got_word.right = o_right_out;
            got_word.index = o_out_index;
            got_word.last  = o_last_of_run;
            sb.check_word(got_word);
            moved = 1'b1;
        end
        if (i_cfg_valid && o_cfg_ready) begin
            sb.set_reg(t_cfg_idx'(i_cfg_index), i_cfg_data);
            cfg_writes++;
            moved = 1'b1;
        end
        stall_cycles = moved ? 0 : stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic signed [SAMPLE_W-1:0] lv;
        logic signed [SAMPLE_W-1:0] rv;
        logic [PHASE_W-1:0]         st;
        logic                       md;
        logic [INDEX_W-1:0]         mx;
        logic                       fl;
        int                         sent;
        int                         blen;
        bit                         broken;

        i_rst_n        = 1'b0;
        push           = 1'b0;
        i_left_sample  = '0;
        i_right_sample = '0;
        i_last_frame   = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_PHASE_STEP;
        i_cfg_data     = '0;
        sb = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: first frame alone, full-scale swings, lone last frame
        push_frame(16'sh8000, 16'sh7FFF, 1'b0);
        push_frame(16'sh7FFF, 16'sh8000, 1'b0);
        push_frame(16'sd0, 16'sd0, 1'b0);
        push_frame(-16'sd1, 16'sd1, 1'b1);
        push_frame(16'sd1234, -16'sd1234, 1'b1);

        // Upsample by 4: full-range ramps both ways, rounding toward minus
        wait_drain();
        write_regs(STEP_QUARTER, 1'b1, MAX_OUT_RESET);
        push_frame(16'sh8000, 16'sh8000, 1'b0);
        push_frame(16'sh7FFF, 16'sh7FFF, 1'b0);
        push_frame(16'sh8000, 16'sh7FFF, 1'b0);
        push_frame(16'sd5, -16'sd7, 1'b1);

        // Zero step in mono: every interval hits the per-frame limit, tail cut
        wait_drain();
        write_regs('0, 1'b0, MAX_OUT_RESET);
        push_frame(16'sd100, 16'sd200, 1'b0);
        push_frame(-16'sd100, -16'sd200, 1'b0);
        push_frame(16'sd300, 16'sd300, 1'b1);

        // Largest step: frames skipped, capacity of three
        wait_drain();
        write_regs({PHASE_W{1'b1}}, 1'b1, 16'd3);
        push_frame(16'sd1, 16'sd2, 1'b0);
        push_frame(16'sd3, 16'sd4, 1'b0);
        push_frame(16'sd5, 16'sd6, 1'b0);
        push_frame(16'sd7, 16'sd8, 1'b1);

        // Zero capacity gives nothing, capacity of one gives one word
        wait_drain();
        write_regs(STEP_HALF, 1'b1, 16'd0);
        push_frame(16'sd10, 16'sd20, 1'b0);
        push_frame(16'sd30, 16'sd40, 1'b1);
        wait_drain();
        write_regs(STEP_HALF, 1'b1, 16'd1);
        push_frame(16'sd10, 16'sd20, 1'b0);
        push_frame(16'sd30, 16'sd40, 1'b0);
        push_frame(16'sd50, 16'sd60, 1'b1);

        // Random buffers under a range of settings
        lv = '0;
        rv = '0;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_drain();
            no_idle = (ph == 0);
            md = 1'($urandom);
            mx = MAX_OUT_RESET;
            case (ph)
                0: begin
                    st = rand_step(64'h8000_0000, 64'h2_0000_0000);
                    md = 1'b1;
                end
                1: begin
                    st = STEP_HALF;
                    md = 1'b1;
                end
                2: begin
                    st = STEP_MIN;
                    md = 1'b0;
                end
                3: st = STEP_MAX;
                4: begin
                    st = rand_step(64'h4000_0000, 64'h4_0000_0000);
                    mx = INDEX_W'($urandom_range(1, 40));
                end
                5: st = rand_step(STEP_MIN, 64'h4_0000_0000);
                6: begin
                    st = rand_step(STEP_MIN, STEP_MAX);
                    mx = INDEX_W'($urandom_range(1, 65535));
                end
                default: st = rand_step(64'h8000_0000, 64'h2_0000_0000);
            endcase
            write_regs(st, md, mx);
            if (ph == 1) hold_req = 1'b1;

            sent = 0;
            while (sent < PHASE_FRAMES) begin
                blen   = $urandom_range(1, 10);
                broken = ($urandom_range(0, 9) == 0);
                for (int k = 0; k < blen; k++) begin
                    lv = pick_sample(lv);
                    rv = pick_sample(rv);
                    fl = broken ? 1'($urandom) : (k == blen - 1);
                    push_frame(lv, rv, fl);
                end
                sent += blen;
            end
        end

        wait_drain();
        $display("Run covered %0d frames and %0d output words with %0d register writes,",
                 sb.frames, sb.words, cfg_writes);
        $display("including capacity limits, zero and largest steps, mono and a stalled reader.");
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/lprs_pkg.sv
hdl/lprs_front.sv
hdl/lprs_seq.sv
hdl/lprs_out.sv
hdl/linear_pcm_resampler_s16.sv
sim/linear_pcm_resampler_s16_tb.sv
